>>> design/ptd_pkg.sv
// shared types and constants of the periodic task dispatcher
package ptd_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int COUNT_W     = 32;
	localparam int PERIOD_W    = 16;

	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_CREATE   = 3'd1,
		ACT_DELETE   = 3'd2,
		ACT_ACTIVATE = 3'd3,
		ACT_SUSPEND  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOT_OK = 2'd1,
		ST_NULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMD,
		S_TICK_RD,
		S_TICK_CHK,
		S_TICK_DIV
	} state_t;

	typedef struct packed {
		logic                registered;
		logic                active;
		logic [PERIOD_W-1:0] period;
	} entry_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_rsp_t;

endpackage

>>> design/periodic_task_dispatcher_core.sv
// periodic task dispatcher: slot table, tick count and command/tick sequencer
//
// usage
//   one input beat is taken at a rising edge with start high and busy low:
//   action, task_index, period and handler_present
//   results leave on status, is_dispatch, due_task and last, each shown for
//   exactly one cycle while strobe is high; the receiver cannot stall them
// commands (create, delete, activate, suspend, unknown codes)
//   one status beat with last set, registered out of the command state
//   entered at the accepting edge; busy is low again while the beat is shown
// tick
//   count increments, then slots are walked in ascending order through the
//   slot memory (registered read); an active slot with a nonzero period
//   goes through the bit-serial remainder unit, 32 iterations; busy stays
//   high for the whole walk; each due slot is sent as one dispatch beat,
//   the final one marked last, at most eight; a tick with nothing due
//   sends no beat
// reset
//   arst_n clears the count, the slot valid bits and the sequencer; the
//   table then reads as empty, no clearing sweep needed
module periodic_task_dispatcher_core #(
	parameter int NUM_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [7:0]  task_index,
	input  logic [15:0] period,
	input  logic        handler_present,
	output logic        strobe,
	output logic [1:0]  status,
	output logic        is_dispatch,
	output logic [7:0]  due_task,
	output logic        last
);
	import ptd_pkg::*;

	localparam int          IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int          SLOT_W = $clog2(NUM_TASKS + 1);
	localparam logic [7:0]  NT_W8  = 8'(NUM_TASKS);

	// sequencer state
	state_t                state_q, state_d;
	logic [SLOT_W-1:0]     slot_q, slot_d;
	logic [RES_CNT_W-1:0]  n_q, n_d;
	logic                  pend_q, pend_d;
	logic [7:0]            pend_task_q, pend_task_d;
	logic [COUNT_W-1:0]    count_q, count_d;

	// latched command beat
	logic [2:0]            act_q;
	logic [7:0]            idx_q;
	logic [PERIOD_W-1:0]   per_q;
	logic                  hnd_q;

	// result registers
	logic                  strobe_q;
	logic [1:0]            status_q;
	logic                  disp_q;
	logic [7:0]            task_q;
	logic                  last_q;

	logic                  accept;
	logic                  emit;
	status_t               emit_status;
	logic                  emit_disp;
	logic [7:0]            emit_task;
	logic                  emit_last;

	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	entry_t                rd_data;
	logic                  wr_en;
	entry_t                wr_data;
	logic                  div_start;
	rem_rsp_t              rem_rsp;
	logic                  in_range;
	logic                  occupied;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign in_range = (idx_q < NT_W8);
	assign occupied = in_range && rd_data.registered;

	ptd_slot_mem #(
		.NUM_TASKS (NUM_TASKS),
		.IDX_W     (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_q[IDX_W-1:0]),
		.wr_data (wr_data)
	);

	ptd_rem_unit u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (count_q),
		.divisor  (rd_data.period),
		.rsp      (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			slot_q   <= '0;
			n_q      <= '0;
			pend_q   <= 1'b0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			slot_q   <= slot_d;
			n_q      <= n_d;
			pend_q   <= pend_d;
			count_q  <= count_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		pend_task_q <= pend_task_d;
		if (accept) begin
			act_q <= action;
			idx_q <= task_index;
			per_q <= period;
			hnd_q <= handler_present;
		end
		if (emit) begin
			status_q <= emit_status;
			disp_q   <= emit_disp;
			task_q   <= emit_task;
			last_q   <= emit_last;
		end
	end

	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		n_d         = n_q;
		pend_d      = pend_q;
		pend_task_d = pend_task_q;
		count_d     = count_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_disp   = 1'b0;
		emit_task   = '0;
		emit_last   = 1'b1;
		rd_en       = 1'b0;
		rd_addr     = slot_q[IDX_W-1:0];
		wr_en       = 1'b0;
		wr_data     = '0;
		div_start   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_TICK) begin
						count_d = count_q + 1'b1;
						slot_d  = '0;
						n_d     = '0;
						pend_d  = 1'b0;
						state_d = S_TICK_RD;
					end else begin
						// slot lookup, only for an index inside the table
						rd_en   = (task_index < NT_W8);
						rd_addr = task_index[IDX_W-1:0];
						state_d = S_CMD;
					end
				end
			end
			S_CMD: begin
				emit    = 1'b1;
				state_d = S_IDLE;
				case (act_q) inside
					ACT_CREATE: begin
						if (!hnd_q) begin
							emit_status = ST_NULL;
						end else if (!in_range || occupied) begin
							emit_status = ST_NOT_OK;
						end else begin
							wr_en   = 1'b1;
							wr_data = '{registered: 1'b1, active: 1'b0, period: per_q};
						end
					end
					ACT_DELETE: begin
						if (occupied) begin
							wr_en = 1'b1;
						end else begin
							emit_status = ST_NOT_OK;
						end
					end
					ACT_ACTIVATE, ACT_SUSPEND: begin
						if (occupied) begin
							wr_en   = 1'b1;
							wr_data = '{registered: 1'b1,
								active: (act_q == ACT_ACTIVATE),
								period: rd_data.period};
						end else begin
							emit_status = ST_NOT_OK;
						end
					end
					default: begin
						emit_status = ST_NOT_OK;
					end
				endcase
			end
			S_TICK_RD: begin
				if (slot_q == SLOT_W'(NUM_TASKS) || n_q == RES_CNT_W'(MAX_RESULTS)) begin
					// walk over: the held dispatch is the final beat
					emit      = pend_q;
					emit_disp = 1'b1;
					emit_task = pend_task_q;
					pend_d    = 1'b0;
					state_d   = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_TICK_CHK;
				end
			end
			S_TICK_CHK: begin
				if (rd_data.active && rd_data.period != '0) begin
					div_start = 1'b1;
					state_d   = S_TICK_DIV;
				end else begin
					slot_d  = slot_q + 1'b1;
					state_d = S_TICK_RD;
				end
			end
			S_TICK_DIV: begin
				if (rem_rsp.done) begin
					if (rem_rsp.zero) begin
						// release the previous due slot, hold this one back
						emit        = pend_q;
						emit_disp   = 1'b1;
						emit_task   = pend_task_q;
						emit_last   = 1'b0;
						n_d         = n_q + 1'b1;
						pend_d      = 1'b1;
						pend_task_d = 8'(slot_q);
					end
					slot_d  = slot_q + 1'b1;
					state_d = S_TICK_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign is_dispatch = disp_q;
	assign due_task    = task_q;
	assign last        = last_q;

endmodule

>>> design/ptd_slot_mem.sv
// slot table memory with one read and one write port, per-entry valid bits
module ptd_slot_mem #(
	parameter int NUM_TASKS = 8,
	parameter int IDX_W     = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output ptd_pkg::entry_t  rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  ptd_pkg::entry_t  wr_data
);
	import ptd_pkg::*;

	entry_t               mem [NUM_TASKS];
	entry_t               rd_q;
	logic                 rd_vld_q;
	logic [NUM_TASKS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// an entry never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

>>> design/ptd_rem_unit.sv
// bit-serial restoring remainder of the tick count by a slot period
module ptd_rem_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ptd_pkg::COUNT_W-1:0]   dividend,
	input  logic [ptd_pkg::PERIOD_W-1:0]  divisor,
	output ptd_pkg::rem_rsp_t             rsp
);
	import ptd_pkg::*;

	localparam int STEP_W = $clog2(COUNT_W);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [COUNT_W-1:0]  dvd_q;
	logic [PERIOD_W-1:0] dvs_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;

	assign trial = {rem_q, dvd_q[COUNT_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(COUNT_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COUNT_W-2:0], 1'b0};
			// partial remainder stays below the divisor
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[PERIOD_W-1:0];
			end else begin
				rem_q <= trial[PERIOD_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = (rem_q == '0);

endmodule

>>> design/ptd_checker.sv
// port-level checks of the periodic task dispatcher, bound to the top level
module ptd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  action,
	input logic        strobe,
	input logic [1:0]  status,
	input logic        is_dispatch,
	input logic [7:0]  due_task,
	input logic        last
);
	import ptd_pkg::*;

	// a command answers with a single status beat, marked last
	a_cmd_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_TICK) |-> ##2 (strobe && !is_dispatch && last))
		else $error("command status beat missing");

	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !is_dispatch) |-> (last && due_task == '0))
		else $error("command status beat malformed");

	a_disp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_dispatch) |-> (status == ST_OK))
		else $error("dispatch beat with nonzero status");

	// more beats to come means the tick walk is still running
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final beat while idle");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("busy after final beat");

endmodule

bind periodic_task_dispatcher_core ptd_checker u_ptd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.strobe      (strobe),
	.status      (status),
	.is_dispatch (is_dispatch),
	.due_task    (due_task),
	.last        (last)
);

>>> test/periodic_task_dispatcher_core_tb.sv
// testbench of the periodic task dispatcher: directed and random commands and ticks
`timescale 1ns / 100ps

module periodic_task_dispatcher_core_tb;

	import ptd_pkg::*;

	localparam int SLOTS = 8;

	// action codes the block does not define, answered with not_ok
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	// one result beat as the block should send it
	typedef struct packed {
		status_t     status;
		logic        is_dispatch;
		logic [7:0]  due_task;
		logic        last;
	} result_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = '0;
	logic [7:0]  task_index = '0;
	logic [15:0] period = '0;
	logic        handler_present = 1'b0;
	logic        strobe;
	logic [1:0]  status;
	logic        is_dispatch;
	logic [7:0]  due_task;
	logic        last;

	// shadow copy of the slot table and the tick count
	logic [COUNT_W-1:0]  shadow_ticks;
	logic                shadow_registered [SLOTS];
	logic [PERIOD_W-1:0] shadow_period [SLOTS];
	logic                shadow_active [SLOTS];

	result_beat_t awaited_beats[$];
	int unsigned  error_count = 0;
	bit           gaps_on = 1'b1;

	periodic_task_dispatcher_core #(
		.NUM_TASKS(SLOTS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.task_index     (task_index),
		.period         (period),
		.handler_present(handler_present),
		.strobe         (strobe),
		.status         (status),
		.is_dispatch    (is_dispatch),
		.due_task       (due_task),
		.last           (last)
	);

	always #5 clk = ~clk;

	// works out the beats one accepted item causes and updates the shadow table
	function automatic void dispatch_predict(input logic [2:0] act, input logic [7:0] idx,
		input logic [15:0] per, input logic hp);
		result_beat_t beat;
		int           due_list [MAX_RESULTS];
		int           n_due;
		bit           in_range;
		bit           occupied;
		status_t      cmd_status;
		n_due      = 0;
		in_range   = idx < SLOTS;
		occupied   = in_range && shadow_registered[idx];
		cmd_status = ST_OK;
		if (act == ACT_TICK) begin
			shadow_ticks = shadow_ticks + 1'b1;
			for (int i = 0; i < SLOTS && n_due < MAX_RESULTS; i++) begin
				if (shadow_active[i] && shadow_period[i] != '0 &&
						(shadow_ticks % {16'd0, shadow_period[i]}) == '0) begin
					due_list[n_due] = i;
					n_due++;
				end
			end
			for (int k = 0; k < n_due; k++) begin
				beat.status      = ST_OK;
				beat.is_dispatch = 1'b1;
				beat.due_task    = 8'(due_list[k]);
				beat.last        = (k == n_due - 1);
				awaited_beats.push_back(beat);
			end
			return;
		end
		case (act)
			ACT_CREATE: begin
				// the null handler check wins over range and occupancy
				if (!hp) begin
					cmd_status = ST_NULL;
				end else if (!in_range || occupied) begin
					cmd_status = ST_NOT_OK;
				end else begin
					shadow_registered[idx] = 1'b1;
					shadow_period[idx]     = per;
					shadow_active[idx]     = 1'b0;
				end
			end
			ACT_DELETE: begin
				if (occupied) begin
					shadow_registered[idx] = 1'b0;
					shadow_period[idx]     = '0;
					shadow_active[idx]     = 1'b0;
				end else begin
					cmd_status = ST_NOT_OK;
				end
			end
			ACT_ACTIVATE: begin
				if (occupied) shadow_active[idx] = 1'b1;
				else cmd_status = ST_NOT_OK;
			end
			ACT_SUSPEND: begin
				if (occupied) shadow_active[idx] = 1'b0;
				else cmd_status = ST_NOT_OK;
			end
			default: begin
				cmd_status = ST_NOT_OK;
			end
		endcase
		beat.status      = cmd_status;
		beat.is_dispatch = 1'b0;
		beat.due_task    = '0;
		beat.last        = 1'b1;
		awaited_beats.push_back(beat);
	endfunction

	// random pause after a beat: mostly none or short, now and then long
	task automatic idle_gap();
		int unsigned pick;
		int unsigned n_idle;
		pick   = $urandom_range(0, 99);
		n_idle = 0;
		if (gaps_on) begin
			if (pick >= 90) n_idle = $urandom_range(20, 60);
			else if (pick >= 60) n_idle = $urandom_range(1, 3);
		end
		if (n_idle != 0) begin
			start <= 1'b0;
			repeat (n_idle) @(posedge clk);
		end
	endtask

	// offers one item, holds it until the block takes it, then predicts its beats
	task automatic send_item(input logic [2:0] act, input logic [7:0] idx,
		input logic [15:0] per, input logic hp);
		start           <= 1'b1;
		action          <= act;
		task_index      <= idx;
		period          <= per;
		handler_present <= hp;
		@(posedge clk);
		while (busy) @(posedge clk);
		dispatch_predict(act, idx, per, hp);
		idle_gap();
	endtask

	// sender holds off until every awaited beat is in
	task automatic wait_for_results();
		start <= 1'b0;
		while (awaited_beats.size() != 0) @(posedge clk);
	endtask

	task automatic test_command_errors();
		send_item(ACT_CREATE, 8'd0, 16'd1, 1'b0);
		send_item(ACT_CREATE, 8'd255, 16'hffff, 1'b1);
		send_item(ACT_DELETE, 8'd3, 16'd0, 1'b1);
		send_item(ACT_ACTIVATE, 8'd200, 16'd0, 1'b1);
		send_item(ACT_SUSPEND, 8'd8, 16'd0, 1'b1);
		send_item(ACT_SPARE_FIRST, 8'hff, 16'hffff, 1'b1);
		send_item(ACT_SPARE_LAST, 8'd0, 16'd0, 1'b0);
		send_item(ACT_TICK, 8'd0, 16'd0, 1'b0);
		wait_for_results();
	endtask

	// every slot due on the same tick, then a suspended and a zero-period slot
	task automatic test_all_slots_due();
		for (int i = 0; i < SLOTS; i++) send_item(ACT_CREATE, 8'(i), 16'd1, 1'b1);
		send_item(ACT_CREATE, 8'd3, 16'd2, 1'b1);
		for (int i = 0; i < SLOTS; i++) send_item(ACT_ACTIVATE, 8'(i), 16'd0, 1'b0);
		send_item(ACT_TICK, 8'd0, 16'd0, 1'b0);
		send_item(ACT_SUSPEND, 8'd5, 16'd0, 1'b1);
		send_item(ACT_DELETE, 8'd2, 16'd0, 1'b1);
		send_item(ACT_CREATE, 8'd2, 16'd0, 1'b1);
		send_item(ACT_ACTIVATE, 8'd2, 16'd0, 1'b1);
		send_item(ACT_TICK, 8'd0, 16'd0, 1'b0);
		wait_for_results();
	endtask

	// one random item: mostly sensible commands on real slots, some noise
	task automatic send_random_item();
		int unsigned   pick;
		logic [2:0]    act;
		logic [7:0]    idx;
		logic [15:0]   per;
		logic          hp;
		pick = $urandom_range(0, 99);
		if (pick < 35) act = ACT_TICK;
		else if (pick < 55) act = ACT_CREATE;
		else if (pick < 70) act = ACT_DELETE;
		else if (pick < 85) act = ACT_ACTIVATE;
		else if (pick < 93) act = ACT_SUSPEND;
		else act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		idx  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, SLOTS - 1))
			: 8'($urandom_range(SLOTS, 255));
		pick = $urandom_range(0, 99);
		if (pick < 70) per = 16'($urandom_range(1, 6));
		else if (pick < 80) per = '0;
		else per = 16'($urandom);
		hp = ($urandom_range(0, 99) < 90);
		// plain noise: every field drawn over its whole width
		if ($urandom_range(0, 99) < 8) begin
			act = 3'($urandom);
			idx = 8'($urandom);
			per = 16'($urandom);
			hp  = 1'($urandom);
		end
		send_item(act, idx, per, hp);
	endtask

	task automatic test_random_traffic();
		repeat (45) send_random_item();
		wait_for_results();
		// back-to-back stretch with no pauses
		gaps_on = 1'b0;
		repeat (20) send_random_item();
		gaps_on = 1'b1;
		repeat (35) send_random_item();
		wait_for_results();
	endtask

	// compares every strobed beat with the oldest awaited one
	always @(posedge clk) begin : beat_check
		result_beat_t want;
		if (arst_n && strobe) begin
			if (awaited_beats.size() == 0) begin
				$display("%0t: unexpected beat status %0d dispatch %0b task %0d last %0b",
					$time, status, is_dispatch, due_task, last);
				error_count++;
			end else begin
				want = awaited_beats.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					error_count++;
				end
				if (is_dispatch !== want.is_dispatch) begin
					$display("%0t: is_dispatch expected %0b actual %0b", $time,
						want.is_dispatch, is_dispatch);
					error_count++;
				end
				if (due_task !== want.due_task) begin
					$display("%0t: due_task expected %0d actual %0d", $time,
						want.due_task, due_task);
					error_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time, want.last, last);
					error_count++;
				end
			end
		end
	end

	initial begin
		shadow_ticks = '0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_registered[i] = 1'b0;
			shadow_period[i]     = '0;
			shadow_active[i]     = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_command_errors();
		test_all_slots_due();
		test_random_traffic();
		wait_for_results();
		// a last tick may still be walking the table with nothing due
		repeat (400) @(posedge clk);
		if (awaited_beats.size() != 0) begin
			$display("%0t: %0d beats never arrived", $time, awaited_beats.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("periodic_task_dispatcher_core: match");
		end else begin
			$display("periodic_task_dispatcher_core: mismatch");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: run timed out", $time);
		$display("periodic_task_dispatcher_core: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
design/ptd_pkg.sv
design/ptd_slot_mem.sv
design/ptd_rem_unit.sv
design/periodic_task_dispatcher_core.sv
design/ptd_checker.sv
test/periodic_task_dispatcher_core_tb.sv
